FILE: rtl/chip8_interpreter_core_top_defines.svh
// Assertion macros shared by the chip8_interpreter_core RTL.
// No dependencies; take it in by `include where assertions are written.
`ifndef CHIP8_INTERPRETER_CORE_TOP_DEFINES_SVH
`define CHIP8_INTERPRETER_CORE_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define C8IC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("c8ic assertion failed");

// Next-cycle implication, held off during reset.
`define C8IC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("c8ic assertion failed");

`endif

FILE: rtl/c8ic_pkg.sv
// Shared types, constants and helper functions of the CHIP-8 core.
// No dependencies; c8ic_exec, chip8_interpreter_core_top and the testbench import it.
package c8ic_pkg;

    localparam int MEM_BYTES       = 4096;
    localparam int MEM_AW          = 12;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int FRAME_ROWS      = 32;
    localparam int FRAME_COLS      = 64;
    localparam int ROW_AW          = 5;
    localparam int COL_AW          = 6;
    localparam int FONT_BYTES      = 80;
    localparam logic [11:0] PC_RESET = 12'h200;

    typedef enum logic [1:0] {
        CMD_LOAD, CMD_EXEC, CMD_TICK, CMD_ROW
    } c8ic_cmd_t;

    typedef enum logic [1:0] {
        ST_OK, ST_UNKNOWN, ST_OVERFLOW, ST_UNDERFLOW
    } c8ic_status_t;

    // Opcode families (top nibble)
    localparam logic [3:0] OP_SYS     = 4'h0;
    localparam logic [3:0] OP_JP      = 4'h1;
    localparam logic [3:0] OP_CALL    = 4'h2;
    localparam logic [3:0] OP_SE_IMM  = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4;
    localparam logic [3:0] OP_SE_REG  = 4'h5;
    localparam logic [3:0] OP_LD_IMM  = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7;
    localparam logic [3:0] OP_ALU     = 4'h8;
    localparam logic [3:0] OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_LD_I    = 4'hA;
    localparam logic [3:0] OP_JP_V0   = 4'hB;
    localparam logic [3:0] OP_RND     = 4'hC;
    localparam logic [3:0] OP_DRW     = 4'hD;
    localparam logic [3:0] OP_SKEY    = 4'hE;
    localparam logic [3:0] OP_MISC    = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    localparam logic [7:0] FN_GET_DT   = 8'h07;
    localparam logic [7:0] FN_WAIT_KEY = 8'h0A;
    localparam logic [7:0] FN_SET_DT   = 8'h15;
    localparam logic [7:0] FN_SET_ST   = 8'h18;
    localparam logic [7:0] FN_ADD_I    = 8'h1E;
    localparam logic [7:0] FN_FONT     = 8'h29;
    localparam logic [7:0] FN_BCD      = 8'h33;
    localparam logic [7:0] FN_STORE    = 8'h55;
    localparam logic [7:0] FN_LOAD     = 8'h65;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] load_addr;
        logic [7:0]  load_data;
        logic [15:0] key_bitmap;
        logic [7:0]  random_byte;
        logic [4:0]  row_select;
    } c8ic_in_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [11:0] index_value;
        logic [63:0] row_pixels;
        logic        collision;
        logic        frame_changed;
        logic        sound_on;
        logic [1:0]  status;
    } c8ic_out_t;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_ROW, S_F1, S_F2, S_RX, S_RY, S_R0, S_EXE, S_WF,
        S_DRD, S_DWR, S_B0, S_B1, S_B2, S_CRD, S_CWR, S_LRD, S_LWR, S_DONE
    } c8ic_state_t;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [11:0] a);
        if (a < 12'(FONT_BYTES)) return FONT_ROM[a[6:0]];
        return 8'h00;
    endfunction

    function automatic logic [63:0] rotr64(input logic [63:0] v, input logic [5:0] s);
        logic [6:0] ls;
        ls = 7'd64 - {1'b0, s};
        return (v >> s) | (v << ls);
    endfunction

    // Hundreds, tens, ones of a byte, one nibble each
    function automatic logic [11:0] bcd_digits(input logic [7:0] v);
        logic [7:0] r;
        logic [3:0] h;
        logic [3:0] t;
        logic [7:0] o;
        if (v >= 8'd200) begin
            h = 4'd2;
            r = v - 8'd200;
        end else if (v >= 8'd100) begin
            h = 4'd1;
            r = v - 8'd100;
        end else begin
            h = 4'd0;
            r = v;
        end
        t = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r >= 8'(10 * k)) t = t + 4'd1;
        end
        o = r - ({1'b0, t, 3'b000} + {3'b000, t, 1'b0});
        return {h, t, o[3:0]};
    endfunction

endpackage

FILE: rtl/c8ic_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (we) ram_reg[waddr] <= wdata;
        rd_data_reg <= ram_reg[raddr];
    end

    assign rdata = rd_data_reg;
endmodule

FILE: rtl/c8ic_exec.sv
// Sequencer and datapath of the CHIP-8 core around four RAMs.
// Depends on c8ic_pkg and c8ic_ram.
module c8ic_exec #(
    parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  c8ic_pkg::c8ic_in_t   in_item,
    input  logic                 cfg_we,
    input  logic [11:0]          cfg_wdata,
    input  logic                 take,
    output logic                 idle,
    output logic                 done,
    output c8ic_pkg::c8ic_out_t  res
);
    import c8ic_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);

    c8ic_state_t state_reg, state_next;

    logic [MEM_AW-1:0] clr_reg;
    logic [11:0]       pc_reg, idx_reg, stk_reg;
    logic [SPW-1:0]    sp_reg, sp_m1;
    logic [7:0]        dt_reg, st_reg, hi_reg, vx_reg, vy_reg, v0_reg;
    logic [15:0]       op_reg;
    logic [3:0]        cnt_reg;
    logic              flag_reg, hit_reg;
    logic [11:0]       bcd_reg;
    logic [63:0]       row_reg;
    logic              coll_reg, chg_reg;
    logic [1:0]        status_reg;
    logic [15:0]       vvld_reg;
    logic [FRAME_ROWS-1:0] fvld_reg;
    logic              vrd_vld_reg, frd_vld_reg;
    c8ic_in_t          item_reg;

    // RAM ports
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              v_we;
    logic [3:0]        v_waddr, v_raddr;
    logic [7:0]        v_wdata, v_rdata;
    logic              s_we;
    logic [SAW-1:0]    s_waddr, s_raddr;
    logic [11:0]       s_wdata, s_rdata;
    logic              f_we;
    logic [ROW_AW-1:0] f_waddr, f_raddr;
    logic [63:0]       f_wdata, f_rdata;

    // Datapath helpers
    logic [3:0]  x, y, n;
    logic [7:0]  nn;
    logic [11:0] nnn, mem_off;
    logic [ROW_AW-1:0] drow;
    logic [7:0]  vrd;
    logic [63:0] frd, spr;
    logic        hit_new, draw_last;

    // Decode results for the execute cycle
    logic        dx_vwe, dx_flag, dx_push, dx_pop, dx_cls, dx_draw, dx_dt_we, dx_st_we;
    logic [7:0]  dx_vdata;
    logic [8:0]  dx_sum;
    logic [1:0]  dx_status;
    logic [11:0] dx_pc, dx_idx, pc_skip;
    c8ic_state_t dx_next;

    assign x         = op_reg[11:8];
    assign y         = op_reg[7:4];
    assign n         = op_reg[3:0];
    assign nn        = op_reg[7:0];
    assign nnn       = op_reg[11:0];
    assign sp_m1     = sp_reg - SPW'(1);
    assign mem_off   = idx_reg + {8'h00, cnt_reg};
    assign drow      = vy_reg[ROW_AW-1:0] + {1'b0, cnt_reg};
    assign vrd       = vrd_vld_reg ? v_rdata : 8'h00;
    assign frd       = frd_vld_reg ? f_rdata : 64'h0;
    assign spr       = rotr64({mem_rdata, 56'h0}, vx_reg[COL_AW-1:0]);
    assign hit_new   = hit_reg | (|(frd & spr));
    assign draw_last = (cnt_reg == (n - 4'd1));
    assign pc_skip   = pc_reg + 12'd2;
    assign dx_sum    = {1'b0, vx_reg} + {1'b0, vy_reg};

    always_comb begin
        dx_vwe    = 1'b0;
        dx_vdata  = 8'h00;
        dx_flag   = 1'b0;
        dx_push   = 1'b0;
        dx_pop    = 1'b0;
        dx_cls    = 1'b0;
        dx_draw   = 1'b0;
        dx_dt_we  = 1'b0;
        dx_st_we  = 1'b0;
        dx_status = ST_OK;
        dx_pc     = pc_reg;
        dx_idx    = idx_reg;
        dx_next   = S_DONE;
        case (op_reg[15:12])
            OP_SYS: begin
                if (op_reg == OP_CLS) begin
                    dx_cls = 1'b1;
                end else if (op_reg == OP_RET) begin
                    if (sp_reg == '0) begin
                        dx_status = ST_UNDERFLOW;
                    end else begin
                        dx_pop = 1'b1;
                        dx_pc  = stk_reg;
                    end
                end
            end
            OP_JP: dx_pc = nnn;
            OP_CALL: begin
                if (sp_reg >= SPW'(STACK_DEPTH)) begin
                    dx_status = ST_OVERFLOW;
                end else begin
                    dx_push = 1'b1;
                    dx_pc   = nnn;
                end
            end
            OP_SE_IMM:  if (vx_reg == nn) dx_pc = pc_skip;
            OP_SNE_IMM: if (vx_reg != nn) dx_pc = pc_skip;
            OP_SE_REG: begin
                if (n != 4'h0) dx_status = ST_UNKNOWN;
                else if (vx_reg == vy_reg) dx_pc = pc_skip;
            end
            OP_SNE_REG: begin
                if (n != 4'h0) dx_status = ST_UNKNOWN;
                else if (vx_reg != vy_reg) dx_pc = pc_skip;
            end
            OP_LD_IMM: begin
                dx_vwe   = 1'b1;
                dx_vdata = nn;
            end
            OP_ADD_IMM: begin
                dx_vwe   = 1'b1;
                dx_vdata = vx_reg + nn;
            end
            OP_ALU: begin
                dx_vwe = 1'b1;
                case (n)
                    ALU_MOV: dx_vdata = vy_reg;
                    ALU_OR:  dx_vdata = vx_reg | vy_reg;
                    ALU_AND: dx_vdata = vx_reg & vy_reg;
                    ALU_XOR: dx_vdata = vx_reg ^ vy_reg;
                    ALU_ADD: begin
                        dx_vdata = dx_sum[7:0];
                        dx_flag  = dx_sum[8];
                        dx_next  = S_WF;
                    end
                    ALU_SUB: begin
                        dx_vdata = vx_reg - vy_reg;
                        dx_flag  = vx_reg > vy_reg;
                        dx_next  = S_WF;
                    end
                    ALU_SHR: begin
                        dx_vdata = {1'b0, vx_reg[7:1]};
                        dx_flag  = vx_reg[0];
                        dx_next  = S_WF;
                    end
                    ALU_SUBN: begin
                        dx_vdata = vy_reg - vx_reg;
                        dx_flag  = vy_reg > vx_reg;
                        dx_next  = S_WF;
                    end
                    ALU_SHL: begin
                        dx_vdata = {vx_reg[6:0], 1'b0};
                        dx_flag  = vx_reg[7];
                        dx_next  = S_WF;
                    end
                    default: begin
                        dx_vwe    = 1'b0;
                        dx_status = ST_UNKNOWN;
                    end
                endcase
            end
            OP_LD_I:  dx_idx = nnn;
            OP_JP_V0: dx_pc = nnn + {4'h0, v0_reg};
            OP_RND: begin
                dx_vwe   = 1'b1;
                dx_vdata = item_reg.random_byte & nn;
            end
            OP_DRW: begin
                dx_draw = 1'b1;
                dx_next = (n == 4'h0) ? S_WF : S_DRD;
            end
            OP_SKEY: begin
                if (nn == KEY_DOWN) begin
                    if (item_reg.key_bitmap[vx_reg[3:0]]) dx_pc = pc_skip;
                end else if (nn == KEY_UP) begin
                    if (!item_reg.key_bitmap[vx_reg[3:0]]) dx_pc = pc_skip;
                end else begin
                    dx_status = ST_UNKNOWN;
                end
            end
            OP_MISC: begin
                case (nn)
                    FN_GET_DT: begin
                        dx_vwe   = 1'b1;
                        dx_vdata = dt_reg;
                    end
                    FN_WAIT_KEY: ;
                    FN_SET_DT: dx_dt_we = 1'b1;
                    FN_SET_ST: dx_st_we = 1'b1;
                    FN_ADD_I:  dx_idx = idx_reg + {4'h0, vx_reg};
                    FN_FONT:   dx_idx = {6'h00, vx_reg[3:0], 2'b00} + {8'h00, vx_reg[3:0]};
                    FN_BCD:    dx_next = S_B0;
                    FN_STORE:  dx_next = S_CRD;
                    FN_LOAD:   dx_next = S_LRD;
                    default:   dx_status = ST_UNKNOWN;
                endcase
            end
            default: dx_status = ST_UNKNOWN;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:  if (clr_reg == MEM_AW'(MEM_BYTES - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (start) begin
                    case (in_item.cmd)
                        CMD_EXEC: state_next = S_F1;
                        CMD_ROW:  state_next = S_ROW;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_ROW:  state_next = S_DONE;
            S_F1:   state_next = S_F2;
            S_F2:   state_next = S_RX;
            S_RX:   state_next = S_RY;
            S_RY:   state_next = S_R0;
            S_R0:   state_next = S_EXE;
            S_EXE:  state_next = dx_next;
            S_WF:   state_next = S_DONE;
            S_DRD:  state_next = S_DWR;
            S_DWR:  state_next = draw_last ? S_WF : S_DRD;
            S_B0:   state_next = S_B1;
            S_B1:   state_next = S_B2;
            S_B2:   state_next = S_DONE;
            S_CRD:  state_next = S_CWR;
            S_CWR:  state_next = (cnt_reg == x) ? S_DONE : S_CRD;
            S_LRD:  state_next = S_LWR;
            S_LWR:  state_next = (cnt_reg == x) ? S_DONE : S_LRD;
            S_DONE: if (take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // RAM controls
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = mem_off;
        mem_wdata = 8'h00;
        mem_raddr = pc_reg;
        v_we      = 1'b0;
        v_waddr   = x;
        v_wdata   = 8'h00;
        v_raddr   = 4'h0;
        s_we      = 1'b0;
        s_waddr   = sp_reg[SAW-1:0];
        s_wdata   = pc_reg;
        s_raddr   = sp_m1[SAW-1:0];
        f_we      = 1'b0;
        f_waddr   = drow;
        f_wdata   = frd ^ spr;
        f_raddr   = in_item.row_select;
        case (state_reg)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = font_byte(clr_reg);
            end
            S_IDLE: begin
                if (start && (in_item.cmd == CMD_LOAD)) begin
                    mem_we    = 1'b1;
                    mem_waddr = in_item.load_addr;
                    mem_wdata = in_item.load_data;
                end
            end
            S_F1: mem_raddr = pc_reg + 12'd1;
            S_F2: v_raddr = hi_reg[3:0];
            S_RX: v_raddr = y;
            S_EXE: begin
                v_we    = dx_vwe;
                v_wdata = dx_vdata;
                s_we    = dx_push;
            end
            S_WF: begin
                v_we    = 1'b1;
                v_waddr = 4'hF;
                v_wdata = {7'h00, flag_reg};
            end
            S_DRD: begin
                mem_raddr = mem_off;
                f_raddr   = drow;
            end
            S_DWR: f_we = 1'b1;
            S_B0: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = {4'h0, bcd_reg[11:8]};
            end
            S_B1: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + 12'd1;
                mem_wdata = {4'h0, bcd_reg[7:4]};
            end
            S_B2: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + 12'd2;
                mem_wdata = {4'h0, bcd_reg[3:0]};
            end
            S_CRD: v_raddr = cnt_reg;
            S_CWR: begin
                mem_we    = 1'b1;
                mem_wdata = vrd;
            end
            S_LRD: mem_raddr = mem_off;
            S_LWR: begin
                v_we    = 1'b1;
                v_waddr = cnt_reg;
                v_wdata = mem_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            pc_reg      <= PC_RESET;
            idx_reg     <= 12'h000;
            sp_reg      <= '0;
            dt_reg      <= 8'h00;
            st_reg      <= 8'h00;
            vvld_reg    <= '0;
            fvld_reg    <= '0;
            vrd_vld_reg <= 1'b0;
            frd_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vrd_vld_reg <= vvld_reg[v_raddr];
            frd_vld_reg <= fvld_reg[f_raddr];
            if (v_we) vvld_reg[v_waddr] <= 1'b1;
            if (f_we) fvld_reg[f_waddr] <= 1'b1;
            case (state_reg)
                S_CLR: clr_reg <= clr_reg + MEM_AW'(1);
                S_IDLE: begin
                    if (start) begin
                        item_reg   <= in_item;
                        row_reg    <= 64'h0;
                        coll_reg   <= 1'b0;
                        chg_reg    <= 1'b0;
                        status_reg <= ST_OK;
                        if (in_item.cmd == CMD_TICK) begin
                            if (dt_reg != 8'h00) dt_reg <= dt_reg - 8'd1;
                            if (st_reg != 8'h00) st_reg <= st_reg - 8'd1;
                        end
                    end
                end
                S_ROW: row_reg <= frd;
                S_F1:  hi_reg <= mem_rdata;
                S_F2: begin
                    op_reg <= {hi_reg, mem_rdata};
                    pc_reg <= pc_reg + 12'd2;
                end
                S_RX: vx_reg <= vrd;
                S_RY: begin
                    vy_reg  <= vrd;
                    stk_reg <= s_rdata;
                end
                S_R0: v0_reg <= vrd;
                S_EXE: begin
                    pc_reg     <= dx_pc;
                    idx_reg    <= dx_idx;
                    status_reg <= dx_status;
                    flag_reg   <= dx_flag;
                    cnt_reg    <= 4'h0;
                    hit_reg    <= 1'b0;
                    bcd_reg    <= bcd_digits(vx_reg);
                    chg_reg    <= dx_cls | dx_draw;
                    if (dx_push) sp_reg <= sp_reg + SPW'(1);
                    if (dx_pop) sp_reg <= sp_m1;
                    if (dx_cls) fvld_reg <= '0;
                    if (dx_dt_we) dt_reg <= vx_reg;
                    if (dx_st_we) st_reg <= vx_reg;
                end
                S_DWR: begin
                    hit_reg  <= hit_new;
                    flag_reg <= hit_new;
                    coll_reg <= hit_new;
                    cnt_reg  <= cnt_reg + 4'd1;
                end
                S_CWR, S_LWR: cnt_reg <= cnt_reg + 4'd1;
                default: ;
            endcase
            if (cfg_we) pc_reg <= cfg_wdata;
        end
    end

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb begin
        res.program_counter = pc_reg;
        res.index_value     = idx_reg;
        res.row_pixels      = row_reg;
        res.collision       = coll_reg;
        res.frame_changed   = chg_reg;
        res.sound_on        = (st_reg != 8'h00);
        res.status          = status_reg;
    end

    c8ic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
        .clk(aclk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
        .clk(aclk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    c8ic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    c8ic_ram #(.WIDTH(FRAME_COLS), .DEPTH(FRAME_ROWS)) u_frame (
        .clk(aclk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );
endmodule

FILE: rtl/chip8_interpreter_core_top.sv
// Top level of the CHIP-8 core: handshakes, result register, assertions.
// Depends on c8ic_pkg, c8ic_exec and chip8_interpreter_core_top_defines.svh.
//
// Usage:
//   s_valid/s_ready/s_data carry one command transaction: load a memory byte,
//   execute one instruction, tick the timers or read a frame row.
//   m_valid/m_ready/m_data return exactly one result transaction per command.
//   cfg_we/cfg_wdata write the start address and load the PC at once.
// Sequencing: the sequencer issues one access per RAM per cycle, and every
//   RAM read is registered. Loads and ticks go from idle straight to the
//   result; a row read passes through S_ROW, and an instruction fetches its
//   two bytes and reads its registers before it executes.
//   One command is in work at a time; s_ready is high only while the
//   sequencer idles.
// Reset: aresetn (synchronous, active low) clears the control state, then a
//   pass over every main-memory address writes the font and zeros there;
//   s_ready stays low during that pass, configuration writes are still taken.
// Stall: a result waits in the output register while m_ready is low; the
//   next command can be accepted and run, and its result holds inside the
//   core until the output register frees up.
`include "chip8_interpreter_core_top_defines.svh"

module chip8_interpreter_core_top #(
    parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  c8ic_pkg::c8ic_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output c8ic_pkg::c8ic_out_t m_data,
    input  logic                cfg_we,
    input  logic [11:0]         cfg_wdata
);
    import c8ic_pkg::*;

    logic      core_idle, core_done, res_take;
    c8ic_out_t core_res;
    logic      m_valid_reg;
    c8ic_out_t m_data_reg;

    // Take a transaction only while the sequencer idles
    assign s_ready  = core_idle;
    // Move the finished result out when the output register is free or draining
    assign res_take = core_done && (!m_valid_reg || m_ready);

    c8ic_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && s_ready),
        .in_item   (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (res_take),
        .idle      (core_idle),
        .done      (core_done),
        .res       (core_res)
    );

    // Output register: hold until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) m_data_reg <= core_res;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `C8IC_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `C8IC_ASSERT_IMP(a_draw_status_ok, aclk, aresetn, m_valid && m_data.frame_changed, m_data.status == ST_OK)
    `C8IC_ASSERT_IMP(a_row_only_on_read, aclk, aresetn, m_valid && (m_data.row_pixels != 64'h0), !m_data.frame_changed && !m_data.collision && (m_data.status == ST_OK))
endmodule

FILE: sim/chip8_interpreter_core_top_test.sv
// Self-checking testbench for chip8_interpreter_core_top: directed table, then random programs.
// Depends on c8ic_pkg and the chip8_interpreter_core_top RTL; needs nothing else.
`timescale 1ns / 100ps

module chip8_interpreter_core_top_test;
    import c8ic_pkg::*;

    localparam int DEPTH      = STACK_DEPTH_DEF;
    localparam int HOLD_CYCLS = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    c8ic_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    c8ic_out_t   m_data;
    logic        cfg_we;
    logic [11:0] cfg_wdata;

    chip8_interpreter_core_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the core's architectural state
    logic [7:0]  mem_img [MEM_BYTES];
    logic [7:0]  vreg [16];
    logic [11:0] idx_reg;
    logic [11:0] pc_reg;
    logic [11:0] ret_addr [DEPTH];
    int          sp_level;
    logic [7:0]  delay_cnt;
    logic [7:0]  sound_cnt;
    logic [63:0] frame [FRAME_ROWS];

    c8ic_out_t   pending_results [$];
    int          err_count;
    int          sent_count;
    int          recv_count;
    bit          rx_hold_done;

    // Clock and single reset at start of run
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("chip8_interpreter_core_top_test: done, errors");
        $finish;
    end

    task automatic report_err(input string what);
        err_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic reset_shadow();
        for (int a = 0; a < MEM_BYTES; a++) mem_img[a] = (a < FONT_BYTES) ? FONT_ROM[a] : 8'h00;
        for (int r = 0; r < 16; r++) vreg[r] = 8'h00;
        for (int r = 0; r < DEPTH; r++) ret_addr[r] = 12'h000;
        for (int r = 0; r < FRAME_ROWS; r++) frame[r] = 64'd0;
        idx_reg   = 12'h000;
        pc_reg    = PC_RESET;
        sp_level  = 0;
        delay_cnt = 8'h00;
        sound_cnt = 8'h00;
    endtask

    // Advance the shadow state by one transaction and produce its result
    task automatic run_core_item(input c8ic_in_t it, output c8ic_out_t res);
        logic [15:0]  op;
        logic [3:0]   x, y, n;
        logic [7:0]   nn, vx, vy;
        logic [11:0]  nnn;
        logic [63:0]  spr;
        logic [4:0]   row;
        logic [5:0]   sh;
        logic         hit;
        c8ic_status_t st;
        res = '0;
        st  = ST_OK;
        case (c8ic_cmd_t'(it.cmd))
            CMD_LOAD: mem_img[it.load_addr] = it.load_data;
            CMD_TICK: begin
                if (delay_cnt != 0) delay_cnt--;
                if (sound_cnt != 0) sound_cnt--;
            end
            CMD_ROW: res.row_pixels = frame[it.row_select];
            default: begin
                op  = {mem_img[pc_reg], mem_img[12'(pc_reg + 12'd1)]};
                x   = op[11:8];
                y   = op[7:4];
                n   = op[3:0];
                nn  = op[7:0];
                nnn = op[11:0];
                vx  = vreg[x];
                vy  = vreg[y];
                pc_reg = pc_reg + 12'd2;
                case (op[15:12])
                    OP_SYS: begin
                        if (op == OP_CLS) begin
                            for (int r = 0; r < FRAME_ROWS; r++) frame[r] = 64'd0;
                            res.frame_changed = 1'b1;
                        end else if (op == OP_RET) begin
                            if (sp_level == 0) st = ST_UNDERFLOW;
                            else begin
                                sp_level--;
                                pc_reg = ret_addr[sp_level];
                            end
                        end
                    end
                    OP_JP: pc_reg = nnn;
                    OP_CALL: begin
                        if (sp_level >= DEPTH) st = ST_OVERFLOW;
                        else begin
                            ret_addr[sp_level] = pc_reg;
                            sp_level++;
                            pc_reg = nnn;
                        end
                    end
                    OP_SE_IMM:  if (vx == nn) pc_reg = pc_reg + 12'd2;
                    OP_SNE_IMM: if (vx != nn) pc_reg = pc_reg + 12'd2;
                    OP_SE_REG: begin
                        if (n != 0) st = ST_UNKNOWN;
                        else if (vx == vy) pc_reg = pc_reg + 12'd2;
                    end
                    OP_LD_IMM:  vreg[x] = nn;
                    OP_ADD_IMM: vreg[x] = vx + nn;
                    OP_ALU: begin
                        case (n)
                            ALU_MOV: vreg[x] = vy;
                            ALU_OR:  vreg[x] = vx | vy;
                            ALU_AND: vreg[x] = vx & vy;
                            ALU_XOR: vreg[x] = vx ^ vy;
                            ALU_ADD: begin
                                vreg[x]  = vx + vy;
                                vreg[15] = ({1'b0, vx} + {1'b0, vy} > 9'd255) ? 8'd1 : 8'd0;
                            end
                            ALU_SUB: begin
                                vreg[x]  = vx - vy;
                                vreg[15] = (vx > vy) ? 8'd1 : 8'd0;
                            end
                            ALU_SHR: begin
                                vreg[x]  = vx >> 1;
                                vreg[15] = {7'd0, vx[0]};
                            end
                            ALU_SUBN: begin
                                vreg[x]  = vy - vx;
                                vreg[15] = (vy > vx) ? 8'd1 : 8'd0;
                            end
                            ALU_SHL: begin
                                vreg[x]  = vx << 1;
                                vreg[15] = {7'd0, vx[7]};
                            end
                            default: st = ST_UNKNOWN;
                        endcase
                    end
                    OP_SNE_REG: begin
                        if (n != 0) st = ST_UNKNOWN;
                        else if (vx != vy) pc_reg = pc_reg + 12'd2;
                    end
                    OP_LD_I:   idx_reg = nnn;
                    OP_JP_V0:  pc_reg = nnn + {4'd0, vreg[0]};
                    OP_RND:    vreg[x] = it.random_byte & nn;
                    OP_DRW: begin
                        // XOR each sprite row into the frame, wrapping both axes
                        hit = 1'b0;
                        sh  = vx[5:0];
                        for (int i = 0; i < n; i++) begin
                            row = 5'(vy + 8'(i));
                            spr = {mem_img[12'(idx_reg + 12'(i))], 56'd0};
                            if (sh != 0) spr = (spr >> sh) | (spr << (7'd64 - {1'b0, sh}));
                            if ((frame[row] & spr) != 0) hit = 1'b1;
                            frame[row] ^= spr;
                        end
                        vreg[15]          = {7'd0, hit};
                        res.collision     = hit;
                        res.frame_changed = 1'b1;
                    end
                    OP_SKEY: begin
                        if (nn == KEY_DOWN) begin
                            if (it.key_bitmap[vx[3:0]]) pc_reg = pc_reg + 12'd2;
                        end else if (nn == KEY_UP) begin
                            if (!it.key_bitmap[vx[3:0]]) pc_reg = pc_reg + 12'd2;
                        end else st = ST_UNKNOWN;
                    end
                    default: begin
                        case (nn)
                            FN_GET_DT:   vreg[x] = delay_cnt;
                            FN_WAIT_KEY: ;
                            FN_SET_DT:   delay_cnt = vx;
                            FN_SET_ST:   sound_cnt = vx;
                            FN_ADD_I:    idx_reg = idx_reg + {4'd0, vx};
                            FN_FONT:     idx_reg = 12'(vx[3:0]) * 12'd5;
                            FN_BCD: begin
                                mem_img[idx_reg]                = vx / 8'd100;
                                mem_img[12'(idx_reg + 12'd1)] = (vx / 8'd10) % 8'd10;
                                mem_img[12'(idx_reg + 12'd2)] = vx % 8'd10;
                            end
                            FN_STORE:
                                for (int i = 0; i <= x; i++) mem_img[12'(idx_reg + 12'(i))] = vreg[i];
                            FN_LOAD:
                                for (int i = 0; i <= x; i++) vreg[i] = mem_img[12'(idx_reg + 12'(i))];
                            default: st = ST_UNKNOWN;
                        endcase
                    end
                endcase
            end
        endcase
        res.program_counter = pc_reg;
        res.index_value     = idx_reg;
        res.sound_on        = (sound_cnt != 0);
        res.status          = st;
    endtask

    function automatic c8ic_in_t make_item(c8ic_cmd_t c, logic [11:0] a, logic [7:0] d);
        c8ic_in_t it;
        it.cmd         = c;
        it.load_addr   = a;
        it.load_data   = d;
        it.key_bitmap  = 16'($urandom);
        it.random_byte = 8'($urandom);
        it.row_select  = 5'($urandom);
        return it;
    endfunction

    function automatic c8ic_out_t make_result(logic [11:0] pc, c8ic_status_t st);
        c8ic_out_t r;
        r = '0;
        r.program_counter = pc;
        r.status          = st;
        return r;
    endfunction

    // Offer one transaction; hold valid and payload until it is taken
    task automatic send_item(input c8ic_in_t it, input bit typed = 1'b0,
                             input c8ic_out_t want = '0);
        c8ic_out_t pred;
        @(negedge aclk);
        if (!(sent_count >= 600 && sent_count < 800) && $urandom_range(0, 99) < 38) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        run_core_item(it, pred);
        pending_results.insert(pending_results.size(), typed ? want : pred);
        sent_count++;
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_start_addr(input logic [11:0] addr);
        drain_results();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        pc_reg = addr;
    endtask

    function automatic logic [15:0] pick_opcode();
        logic [15:0] op;
        logic [3:0]  fam;
        op  = 16'($urandom);
        fam = op[15:12];
        case (fam)
            OP_SYS: begin
                case ($urandom_range(0, 3))
                    0:       op = OP_CLS;
                    1, 2:    op = OP_RET;
                    default: op = {4'h0, 12'($urandom)};
                endcase
            end
            OP_SE_REG, OP_SNE_REG: if ($urandom_range(0, 4) != 0) op[3:0] = 4'h0;
            OP_ALU: begin
                if ($urandom_range(0, 7) != 0) begin
                    case ($urandom_range(0, 8))
                        0: op[3:0] = ALU_MOV;  1: op[3:0] = ALU_OR;
                        2: op[3:0] = ALU_AND;  3: op[3:0] = ALU_XOR;
                        4: op[3:0] = ALU_ADD;  5: op[3:0] = ALU_SUB;
                        6: op[3:0] = ALU_SHR;  7: op[3:0] = ALU_SUBN;
                        default: op[3:0] = ALU_SHL;
                    endcase
                end
            end
            OP_SKEY: if ($urandom_range(0, 7) != 0) op[7:0] = $urandom_range(0, 1) ? KEY_DOWN : KEY_UP;
            OP_MISC: begin
                if ($urandom_range(0, 7) != 0) begin
                    case ($urandom_range(0, 8))
                        0: op[7:0] = FN_GET_DT;  1: op[7:0] = FN_WAIT_KEY;
                        2: op[7:0] = FN_SET_DT;  3: op[7:0] = FN_SET_ST;
                        4: op[7:0] = FN_ADD_I;   5: op[7:0] = FN_FONT;
                        6: op[7:0] = FN_BCD;     7: op[7:0] = FN_STORE;
                        default: op[7:0] = FN_LOAD;
                    endcase
                end
            end
            default: ;
        endcase
        return op;
    endfunction

    // Place an opcode at the current PC, then execute it
    task automatic run_opcode(input logic [15:0] op);
        send_item(make_item(CMD_LOAD, pc_reg, op[15:8]));
        send_item(make_item(CMD_LOAD, 12'(pc_reg + 12'd1), op[7:0]));
        send_item(make_item(CMD_EXEC, 12'($urandom), 8'($urandom)));
    endtask

    task automatic random_phase(input int quota);
        int stop_at;
        int kind;
        stop_at = sent_count + quota;
        while (sent_count < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 2) begin
                // deep call chain: overflow the stack, then unwind past empty
                for (int k = 0; k < DEPTH + 2; k++) run_opcode({OP_CALL, 12'($urandom)});
                for (int k = 0; k < DEPTH + 2; k++) run_opcode(OP_RET);
            end else if (kind < 17) begin
                send_item(make_item(c8ic_cmd_t'($urandom_range(0, 3)), 12'($urandom),
                                    8'($urandom)));
            end else if (kind < 22) begin
                send_item(make_item(CMD_TICK, 12'($urandom), 8'($urandom)));
            end else begin
                run_opcode(pick_opcode());
            end
        end
    endtask

    typedef struct {
        c8ic_in_t  item;
        bit        typed;
        c8ic_out_t want;
    } dir_row_t;

    // Stimulus
    initial begin
        dir_row_t dir_rows [$];
        dir_row_t dr;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 12'h000;
        err_count = 0;
        sent_count = 0;
        reset_shadow();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table; rows after reset, error codes and the closing tick carry their result
        dr = '{make_item(CMD_TICK, 12'hFFF, 8'hFF), 1'b1, make_result(12'h200, ST_OK)};
        dr.item.key_bitmap = 16'hFFFF; dr.item.random_byte = 8'hFF; dr.item.row_select = 5'd31;
        dir_rows.insert(dir_rows.size(), dr);
        dr = '{make_item(CMD_ROW, 12'h000, 8'h00), 1'b1, make_result(12'h200, ST_OK)};
        dr.item.key_bitmap = 16'h0000; dr.item.random_byte = 8'h00; dr.item.row_select = 5'd31;
        dir_rows.insert(dir_rows.size(), dr);
        dr.item.row_select = 5'd0;
        dir_rows.insert(dir_rows.size(), dr);
        dir_rows.insert(dir_rows.size(),
                        '{make_item(CMD_LOAD, 12'hFFF, 8'hFF), 1'b1, make_result(12'h200, ST_OK)});
        dir_rows.insert(dir_rows.size(),
                        '{make_item(CMD_LOAD, 12'h000, 8'h00), 1'b1, make_result(12'h200, ST_OK)});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_LOAD, 12'h200, 8'h00), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_LOAD, 12'h201, 8'hE0), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_EXEC, 12'h000, 8'h00), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_LOAD, 12'h202, 8'h5A), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_LOAD, 12'h203, 8'hB1), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_EXEC, 12'h000, 8'h00), 1'b1,
                                           make_result(12'h204, ST_UNKNOWN)});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_LOAD, 12'h204, 8'h00), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_LOAD, 12'h205, 8'hEE), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_EXEC, 12'h000, 8'h00), 1'b1,
                                           make_result(12'h206, ST_UNDERFLOW)});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_LOAD, 12'h206, 8'hD0), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_LOAD, 12'h207, 8'h15), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_EXEC, 12'h000, 8'h00), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_LOAD, 12'h208, 8'h12), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_LOAD, 12'h209, 8'h06), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_EXEC, 12'h000, 8'h00), 1'b0, '0});
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_EXEC, 12'h000, 8'h00), 1'b0, '0});
        dr = '{make_item(CMD_ROW, 12'h000, 8'h00), 1'b0, '0};
        dr.item.row_select = 5'd1;
        dir_rows.insert(dir_rows.size(), dr);
        dir_rows.insert(dir_rows.size(), '{make_item(CMD_TICK, 12'h000, 8'h00), 1'b1,
                                           make_result(12'h208, ST_OK)});

        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // Random programs under several start addresses, extremes included
        random_phase(300);
        write_start_addr(12'hFFE);
        random_phase(250);
        write_start_addr(12'h000);
        random_phase(250);
        write_start_addr(12'hFFF);
        random_phase(250);
        write_start_addr(12'($urandom));
        random_phase(250);

        drain_results();
        repeat (50) @(posedge aclk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("chip8_interpreter_core_top_test: done, clean");
        else
            $display("chip8_interpreter_core_top_test: done, errors");
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off
    initial begin
        m_ready      = 1'b0;
        rx_hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!rx_hold_done && recv_count >= 250) begin
                rx_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLS) @(negedge aclk);
            end
            m_ready <= (recv_count >= 600 && recv_count < 800) || ($urandom_range(0, 99) >= 38);
        end
    end

    // Compare each returned transaction against the oldest expectation
    initial begin
        c8ic_out_t want;
        recv_count = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                recv_count++;
                if (pending_results.size() == 0) begin
                    report_err("result with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.program_counter !== want.program_counter)
                        report_err($sformatf("pc %h, want %h", m_data.program_counter,
                                             want.program_counter));
                    if (m_data.index_value !== want.index_value)
                        report_err($sformatf("index %h, want %h", m_data.index_value,
                                             want.index_value));
                    if (m_data.row_pixels !== want.row_pixels)
                        report_err($sformatf("row %h, want %h", m_data.row_pixels,
                                             want.row_pixels));
                    if (m_data.collision !== want.collision)
                        report_err($sformatf("collision %b, want %b", m_data.collision,
                                             want.collision));
                    if (m_data.frame_changed !== want.frame_changed)
                        report_err($sformatf("frame_changed %b, want %b", m_data.frame_changed,
                                             want.frame_changed));
                    if (m_data.sound_on !== want.sound_on)
                        report_err($sformatf("sound_on %b, want %b", m_data.sound_on,
                                             want.sound_on));
                    if (m_data.status !== want.status)
                        report_err($sformatf("status %0d, want %0d", m_data.status,
                                             want.status));
                end
            end
        end
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/c8ic_pkg.sv
rtl/c8ic_ram.sv
rtl/c8ic_exec.sv
rtl/chip8_interpreter_core_top.sv
sim/chip8_interpreter_core_top_test.sv
